// ===== rtl/aml_pstate_package_decoder_macros.svh =====
// Assertion macros used by the decoder top level.
`ifndef AML_PSTATE_PACKAGE_DECODER_MACROS_SVH
`define AML_PSTATE_PACKAGE_DECODER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define APD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("decoder check failed");

// The consequent must hold in the cycle after the antecedent.
`define APD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("decoder check failed");

`endif

// ===== rtl/apd_pkg.sv =====
package apd_pkg;

	localparam logic [7:0] OP_PACKAGE = 8'h12;
	localparam logic [7:0] OP_ZERO    = 8'h00;
	localparam logic [7:0] OP_ONE     = 8'h01;
	localparam logic [7:0] OP_ONES    = 8'hFF;
	localparam logic [7:0] OP_BYTE    = 8'h0A;
	localparam logic [7:0] OP_WORD    = 8'h0B;
	localparam logic [7:0] OP_DWORD   = 8'h0C;
	localparam logic [7:0] OP_QWORD   = 8'h0E;

	localparam int NUM_FIELDS = 6;
	localparam int SLOT_W     = 4;

	typedef enum logic [3:0] {
		PH_OUTER_OP,
		PH_OUTER_LEN,
		PH_OUTER_COUNT,
		PH_SUB_OP,
		PH_SUB_LEN,
		PH_SUB_COUNT,
		PH_INT_OP,
		PH_INT_DATA,
		PH_SKIP,
		PH_HALT
	} phase_t;

	typedef struct packed {
		logic                                 rec;
		logic [3:0]                           idx;
		logic [NUM_FIELDS-1:0][31:0]          val;
		logic                                 done;
		logic [4:0]                           cnt;
	} word_t;

endpackage

// ===== rtl/apd_front.sv =====
module apd_front import apd_pkg::*; #(
	parameter int MAX_ENTRIES      = 16,
	parameter int VALUES_PER_ENTRY = 6
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output logic       push,
	output word_t      word
);

	localparam int CW = $clog2(MAX_ENTRIES + 1);

	phase_t                      phase_q, phase_d;
	logic [1:0]                  lb_left_q, lb_left_d;
	logic [1:0]                  ext_q, ext_d;
	logic [27:0]                 len_q, len_d;
	logic [7:0]                  outer_q, outer_d;
	logic [7:0]                  sub_left_q, sub_left_d;
	logic [27:0]                 sb_q, sb_d;
	logic [SLOT_W-1:0]           slot_q, slot_d;
	logic [3:0]                  int_left_q, int_left_d;
	logic [2:0]                  pos_q, pos_d;
	logic [31:0]                 acc_q, acc_d;
	logic [NUM_FIELDS-1:0][31:0] vals_q, vals_d;
	logic [CW-1:0]               cnt_q, cnt_d;
	logic                        emit, finish, commit;
	logic [31:0]                 cval;
	logic [3:0]                  nbytes;
	logic [1:0]                  lidx;
	logic [2:0]                  need;
	logic [27:0]                 payload_len;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_OUTER_OP;
			lb_left_q  <= '0;
			ext_q      <= '0;
			len_q      <= '0;
			outer_q    <= '0;
			sub_left_q <= '0;
			sb_q       <= '0;
			slot_q     <= '0;
			int_left_q <= '0;
			pos_q      <= '0;
			acc_q      <= '0;
			vals_q     <= '0;
			cnt_q      <= '0;
		end else if (take) begin
			phase_q    <= phase_d;
			lb_left_q  <= lb_left_d;
			ext_q      <= ext_d;
			len_q      <= len_d;
			outer_q    <= outer_d;
			sub_left_q <= sub_left_d;
			sb_q       <= sb_d;
			slot_q     <= slot_d;
			int_left_q <= int_left_d;
			pos_q      <= pos_d;
			acc_q      <= acc_d;
			vals_q     <= vals_d;
			cnt_q      <= cnt_d;
		end
	end

	always_comb begin
		phase_d     = phase_q;
		lb_left_d   = lb_left_q;
		ext_d       = ext_q;
		len_d       = len_q;
		outer_d     = outer_q;
		sub_left_d  = sub_left_q;
		sb_d        = sb_q;
		slot_d      = slot_q;
		int_left_d  = int_left_q;
		pos_d       = pos_q;
		acc_d       = acc_q;
		vals_d      = vals_q;
		cnt_d       = cnt_q;
		emit        = 1'b0;
		finish      = 1'b0;
		commit      = 1'b0;
		cval        = '0;
		nbytes      = '0;
		lidx        = ext_q - lb_left_q;
		need        = {1'b0, ext_q} + 3'd2;
		payload_len = len_q - 28'(need);

		unique case (phase_q)
			PH_OUTER_OP, PH_SUB_OP: begin
				lb_left_d = '0;
				if (data_byte == OP_PACKAGE) begin
					phase_d = (phase_q == PH_OUTER_OP) ? PH_OUTER_LEN : PH_SUB_LEN;
				end else begin
					phase_d = PH_HALT;
				end
			end
			PH_OUTER_LEN, PH_SUB_LEN: begin
				if (lb_left_q == 2'd0) begin
					ext_d     = data_byte[7:6];
					lb_left_d = data_byte[7:6];
					len_d     = (data_byte[7:6] == 2'd0) ? {22'd0, data_byte[5:0]}
						: {24'd0, data_byte[3:0]};
				end else begin
					unique case (lidx)
						2'd0:    len_d = len_q | {16'd0, data_byte, 4'd0};
						2'd1:    len_d = len_q | {8'd0, data_byte, 12'd0};
						2'd2:    len_d = len_q | {data_byte, 20'd0};
						default: len_d = len_q;
					endcase
					lb_left_d = lb_left_q - 2'd1;
				end
				if (lb_left_d == 2'd0) begin
					phase_d = (phase_q == PH_OUTER_LEN) ? PH_OUTER_COUNT : PH_SUB_COUNT;
				end
			end
			PH_OUTER_COUNT: begin
				outer_d = data_byte;
				phase_d = (data_byte == 8'd0) ? PH_HALT : PH_SUB_OP;
			end
			PH_SUB_COUNT: begin
				if (len_q < 28'(need)) begin
					phase_d = PH_HALT;
				end else begin
					sb_d       = payload_len;
					sub_left_d = data_byte;
					vals_d     = '0;
					slot_d     = '0;
					int_left_d = '0;
					acc_d      = '0;
					phase_d    = (data_byte != 8'd0) ? PH_INT_OP : PH_SKIP;
					if (payload_len == 28'd0) begin
						finish = 1'b1;
					end
				end
			end
			PH_INT_OP, PH_INT_DATA, PH_SKIP: begin
				if (sb_q != 28'd0) begin
					sb_d = sb_q - 28'd1;
				end
				if (phase_q == PH_INT_OP) begin
					unique case (data_byte)
						OP_ZERO: begin commit = 1'b1; cval = 32'd0; end
						OP_ONE:  begin commit = 1'b1; cval = 32'd1; end
						OP_ONES: begin commit = 1'b1; cval = 32'hFFFF_FFFF; end
						OP_BYTE:  nbytes = 4'd1;
						OP_WORD:  nbytes = 4'd2;
						OP_DWORD: nbytes = 4'd4;
						OP_QWORD: nbytes = 4'd8;
						default:  phase_d = PH_SKIP;
					endcase
					if (nbytes != 4'd0) begin
						int_left_d = nbytes;
						acc_d      = '0;
						pos_d      = '0;
						phase_d    = PH_INT_DATA;
					end
				end else if (phase_q == PH_INT_DATA) begin
					if (!pos_q[2]) begin
						unique case (pos_q[1:0])
							2'd0: acc_d = acc_q | {24'd0, data_byte};
							2'd1: acc_d = acc_q | {16'd0, data_byte, 8'd0};
							2'd2: acc_d = acc_q | {8'd0, data_byte, 16'd0};
							2'd3: acc_d = acc_q | {data_byte, 24'd0};
						endcase
					end
					pos_d = pos_q + 3'd1;
					if (int_left_q != 4'd0) begin
						int_left_d = int_left_q - 4'd1;
					end
					if (int_left_d == 4'd0) begin
						commit = 1'b1;
						cval   = acc_d;
					end
				end
				if (commit) begin
					for (int k = 0; k < NUM_FIELDS; k++) begin
						if (slot_q == SLOT_W'(k)) begin
							vals_d[k] = cval;
						end
					end
					slot_d = slot_q + SLOT_W'(1);
					if (sub_left_q != 8'd0) begin
						sub_left_d = sub_left_q - 8'd1;
					end
					phase_d = (sub_left_d != 8'd0 && slot_d < SLOT_W'(VALUES_PER_ENTRY))
						? PH_INT_OP : PH_SKIP;
				end
				if (sb_d == 28'd0) begin
					finish = 1'b1;
				end
			end
			default: phase_d = PH_HALT;
		endcase

		if (finish) begin
			emit  = 1'b1;
			cnt_d = cnt_q + CW'(1);
			if (outer_q != 8'd0) begin
				outer_d = outer_q - 8'd1;
			end
			phase_d = (outer_d == 8'd0 || cnt_d >= CW'(MAX_ENTRIES)) ? PH_HALT : PH_SUB_OP;
		end

		if (last_byte && !emit &&
			(phase_d == PH_INT_OP || phase_d == PH_INT_DATA || phase_d == PH_SKIP)) begin
			emit  = 1'b1;
			cnt_d = cnt_q + CW'(1);
		end

		push      = take && (emit || last_byte);
		word.rec  = emit;
		word.idx  = emit ? 4'(cnt_q) : 4'd0;
		word.val  = emit ? vals_d : '0;
		word.done = last_byte;
		word.cnt  = last_byte ? 5'(cnt_d) : 5'd0;

		if (last_byte) begin
			phase_d    = PH_OUTER_OP;
			lb_left_d  = '0;
			ext_d      = '0;
			len_d      = '0;
			outer_d    = '0;
			sub_left_d = '0;
			sb_d       = '0;
			slot_d     = '0;
			int_left_d = '0;
			pos_d      = '0;
			acc_d      = '0;
			vals_d     = '0;
			cnt_d      = '0;
		end
	end

endmodule

// ===== rtl/apd_queue.sv =====
module apd_queue import apd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  word_t push_word,
	output logic  full,
	output logic  out_valid,
	input  logic  out_stall,
	output word_t head
);

	localparam int DEPTH = 4;

	word_t      mem [DEPTH];
	logic [1:0] wptr_q, rptr_q;
	logic [2:0] count_q;
	logic       pop;

	assign full      = (count_q == 3'(DEPTH));
	assign out_valid = (count_q != 3'd0);
	assign pop       = out_valid && !out_stall;
	assign head      = mem[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 2'd1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 2'd1;
			end
			count_q <= count_q + 3'(push) - 3'(pop);
		end
	end

endmodule

// ===== rtl/aml_pstate_package_decoder.sv =====
// Channel   Direction  Handshake           Payload
// input     in         in_valid/in_stall   data_byte, last_byte
// output    out        out_valid/out_stall record_valid .. records_emitted
//
// One buffer byte is taken per clock while the queue is not full; the header and
// integer parser decides each byte combinationally.
// A result appears on the output at the earliest in the cycle after its byte is accepted.
// A four-word queue sits between the parser and the output, and in_stall is high only
// while that queue is full.
// Reset clears the parser to expect a new outer package and empties the queue.
`include "aml_pstate_package_decoder_macros.svh"
module aml_pstate_package_decoder import apd_pkg::*; #(
	parameter int MAX_ENTRIES      = 16,
	parameter int VALUES_PER_ENTRY = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        record_valid,
	output logic [3:0]  entry_index,
	output logic [31:0] core_frequency,
	output logic [31:0] power_draw,
	output logic [31:0] transition_latency,
	output logic [31:0] bus_master_latency,
	output logic [31:0] control_word,
	output logic [31:0] status_word,
	output logic        buffer_done,
	output logic [4:0]  records_emitted
);

	logic  take, push, full;
	word_t front_word, head;

	assign in_stall = full;
	assign take     = in_valid && !full;

	apd_front #(
		.MAX_ENTRIES      (MAX_ENTRIES),
		.VALUES_PER_ENTRY (VALUES_PER_ENTRY)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.push      (push),
		.word      (front_word)
	);

	apd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (front_word),
		.full      (full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.head      (head)
	);

	assign record_valid       = head.rec;
	assign entry_index        = head.idx;
	assign core_frequency     = head.val[0];
	assign power_draw         = head.val[1];
	assign transition_latency = head.val[2];
	assign bus_master_latency = head.val[3];
	assign control_word       = head.val[4];
	assign status_word        = head.val[5];
	assign buffer_done        = head.done;
	assign records_emitted    = head.cnt;

	`APD_ASSERT_SAME(a_no_empty_word, clk, arst_n, out_valid && !buffer_done, record_valid)
	`APD_ASSERT_SAME(a_empty_zero, clk, arst_n, out_valid && !record_valid, core_frequency == 32'd0 && entry_index == 4'd0)
	`APD_ASSERT_NEXT(a_last_queued, clk, arst_n, in_valid && !in_stall && last_byte, out_valid)

endmodule
